// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define ZB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When cond holds, check prop at the next clock edge.
`define ZB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/zbts_pkg.sv
// ----------------------------------------------------------------------------
// zbts_pkg
// Types and constants of the z-buffered blended texture span core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package zbts_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int BLEND_ENTRIES = 65536;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [1:0] {
    KIND_SPAN     = 2'd0,
    KIND_PIXEL    = 2'd1,
    KIND_TEX_WR   = 2'd2,
    KIND_BLEND_WR = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_U_STEP        = 3'd0,
    CFG_V_STEP        = 3'd1,
    CFG_Z_STEP        = 3'd2,
    CFG_TEXTURE_LOG2  = 3'd3,
    CFG_RIGHT_TO_LEFT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start_u;
    logic [31:0] start_v;
    logic [31:0] start_z;
    logic [15:0] old_depth;
    logic [7:0]  dest_colour;
    logic [15:0] table_addr;
    logic [7:0]  table_data;
  } in_item_t;

  typedef struct packed {
    logic        depth_write;
    logic [15:0] new_depth;
    logic        colour_write;
    logic [7:0]  new_colour;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] z_int;
    logic [15:0] old_depth;
    logic [7:0]  dest_colour;
    logic [7:0]  texel;
    logic [15:0] table_addr;
    logic [7:0]  table_data;
  } mid_item_t;

endpackage

// File: rtl/zbts_ram.sv
// ----------------------------------------------------------------------------
// zbts_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module zbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/zbts_fifo.sv
// ----------------------------------------------------------------------------
// zbts_fifo
// Small register queue; the caller keeps it from overflow by its count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zbts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign count    = count_r;

  `ZB_ASSERT(a_no_overflow, !(push && !pop && count_r == CW'(DEPTH)), "fifo overflow")
  `ZB_ASSERT(a_no_underflow, !(pop && count_r == '0), "fifo underflow")
  `ZB_ASSERT_NEXT(a_full_holds, count_r == CW'(DEPTH) && !pop, count_r == CW'(DEPTH), "full fifo lost an entry without pop")

endmodule

// File: rtl/zbts_front.sv
// ----------------------------------------------------------------------------
// zbts_front
// Accepts transactions, holds the span accumulators and configuration,
// and looks up the texel; passes classified items to the middle queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module zbts_front import zbts_pkg::*; #(
  parameter int MAX_TEXTURE_LOG2 = 6,
  parameter int MID_DEPTH        = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  in_item_t                       in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  output logic                           mid_push,
  output mid_item_t                      mid_data
);

  localparam int P   = MAX_TEXTURE_LOG2;
  localparam int AW  = 2 * MAX_TEXTURE_LOG2;
  localparam int LGW = $clog2(MAX_TEXTURE_LOG2 + 1);
  localparam int CW  = $clog2(MID_DEPTH + 1);

  logic [31:0] u_step_r, v_step_r, z_step_r;
  logic [2:0]  tex_log2_r;
  logic        rtl_r;
  logic [31:0] u_r, u_nxt, v_r, v_nxt, z_r, z_nxt;

  logic        f1_valid_r;
  kind_t       f1_kind_r;
  logic [15:0] f1_z_r, f1_old_depth_r, f1_table_addr_r;
  logic [7:0]  f1_dest_r, f1_table_data_r;

  logic          accept;
  logic [CW:0]   occ;
  logic [LGW-1:0] lg;
  logic [P:0]    side_ext, side_m1;
  logic [P-1:0]  side_mask, col, rowbits;
  logic [AW-1:0] tex_raddr;
  logic [7:0]    tex_rdata;
  logic          tex_we;

  assign occ       = {1'b0, mid_count} + (CW+1)'(f1_valid_r);
  assign in_full   = occ >= (CW+1)'(MID_DEPTH);
  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_step_r   <= '0;
      v_step_r   <= '0;
      z_step_r   <= '0;
      tex_log2_r <= 3'd6;
      rtl_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_U_STEP:        u_step_r   <= cfg_data;
        CFG_V_STEP:        v_step_r   <= cfg_data;
        CFG_Z_STEP:        z_step_r   <= cfg_data;
        CFG_TEXTURE_LOG2:  tex_log2_r <= cfg_data[2:0];
        CFG_RIGHT_TO_LEFT: rtl_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    z_nxt = z_r;
    if (accept && in_data.kind == KIND_SPAN) begin
      u_nxt = in_data.start_u;
      v_nxt = in_data.start_v;
      z_nxt = in_data.start_z;
    end else if (accept && in_data.kind == KIND_PIXEL) begin
      if (rtl_r) begin
        u_nxt = u_r - u_step_r;
        v_nxt = v_r - v_step_r;
        z_nxt = z_r - z_step_r;
      end else begin
        u_nxt = u_r + u_step_r;
        v_nxt = v_r + v_step_r;
        z_nxt = z_r + z_step_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r        <= '0;
      v_r        <= '0;
      z_r        <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      u_r        <= u_nxt;
      v_r        <= v_nxt;
      z_r        <= z_nxt;
      f1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_kind_r       <= in_data.kind;
      f1_z_r          <= z_r[FRAC_BITS +: 16];
      f1_old_depth_r  <= in_data.old_depth;
      f1_dest_r       <= in_data.dest_colour;
      f1_table_addr_r <= in_data.table_addr;
      f1_table_data_r <= in_data.table_data;
    end
  end

  // texel address: v integer part as row, u integer part as column
  always_comb begin
    lg        = (int'(tex_log2_r) > MAX_TEXTURE_LOG2) ? LGW'(MAX_TEXTURE_LOG2)
                                                       : LGW'(tex_log2_r);
    side_ext  = (P+1)'(1) << lg;
    side_m1   = side_ext - (P+1)'(1);
    side_mask = side_m1[P-1:0];
    col       = u_r[FRAC_BITS +: P] & side_mask;
    rowbits   = v_r[FRAC_BITS +: P] & side_mask;
    tex_raddr = ({{P{1'b0}}, rowbits} << lg) | {{P{1'b0}}, col};
  end

  assign tex_we = accept && in_data.kind == KIND_TEX_WR;

  zbts_ram #(
    .WIDTH (8),
    .DEPTH (1 << AW)
  ) u_tex_ram (
    .clk   (clk),
    .we    (tex_we),
    .waddr (in_data.table_addr[AW-1:0]),
    .wdata (in_data.table_data),
    .re    (accept),
    .raddr (tex_raddr),
    .rdata (tex_rdata)
  );

  assign mid_push = f1_valid_r;

  always_comb begin
    mid_data.kind        = f1_kind_r;
    mid_data.z_int       = f1_z_r;
    mid_data.old_depth   = f1_old_depth_r;
    mid_data.dest_colour = f1_dest_r;
    mid_data.texel       = tex_rdata;
    mid_data.table_addr  = f1_table_addr_r;
    mid_data.table_data  = f1_table_data_r;
  end

endmodule

// File: rtl/zbts_back.sv
// ----------------------------------------------------------------------------
// zbts_back
// Takes classified items from the middle queue, runs the depth and
// transparency test, reads or writes the blend table and forms results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module zbts_back import zbts_pkg::*; #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  input  mid_item_t                      mid_data,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output out_item_t                      out_data
);

  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int BAW = $clog2(BLEND_ENTRIES);

  logic [OCW:0]  occ;
  logic          pass;
  logic          blend_we;
  logic [7:0]    blend_rdata;
  logic          b1_valid_r;
  logic          b1_pass_r;
  logic [15:0]   b1_z_r;

  assign occ     = {1'b0, out_count} + (OCW+1)'(b1_valid_r);
  assign mid_pop = (mid_count != '0) && (occ < (OCW+1)'(OUT_DEPTH));

  assign pass = (mid_data.kind == KIND_PIXEL) && (mid_data.z_int <= mid_data.old_depth)
             && (mid_data.texel != 8'd0);
  assign blend_we = mid_pop && mid_data.kind == KIND_BLEND_WR;

  zbts_ram #(
    .WIDTH (8),
    .DEPTH (BLEND_ENTRIES)
  ) u_blend_ram (
    .clk   (clk),
    .we    (blend_we),
    .waddr (mid_data.table_addr[BAW-1:0]),
    .wdata (mid_data.table_data),
    .re    (mid_pop),
    .raddr ({mid_data.dest_colour, mid_data.texel}),
    .rdata (blend_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else begin
      b1_valid_r <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      b1_pass_r <= pass;
      b1_z_r    <= mid_data.z_int;
    end
  end

  assign out_push = b1_valid_r;

  always_comb begin
    out_data.depth_write  = b1_pass_r;
    out_data.new_depth    = b1_pass_r ? b1_z_r : 16'd0;
    out_data.colour_write = b1_pass_r;
    out_data.new_colour   = b1_pass_r ? blend_rdata : 8'd0;
  end

endmodule

// File: rtl/zbuffered_blended_texture_span_core.sv
// Path: a transaction is registered in the front with its texel read, queued in the
// middle queue, registered in the back with its blend read, then queued for out_data.
// Throughput: one transaction per cycle while in_full is low, set by the accumulator
// adders and one access per cycle on each read port of the texture and blend RAMs.
// Reset: synchronous, active low; clears accumulators, configuration and queue
// state. Texture and blend RAMs are not cleared and hold nothing until written.
// ----------------------------------------------------------------------------
// zbuffered_blended_texture_span_core
// Z-buffered, textured, blended span fragment engine: front with texture
// lookup, middle queue, back with depth test and blend table, result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module zbuffered_blended_texture_span_core import zbts_pkg::*; #(
  parameter int MAX_TEXTURE_LOG2 = 6,
  parameter int MID_DEPTH        = 4,
  parameter int OUT_DEPTH        = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [MCW-1:0] mid_count;
  logic           mid_push, mid_pop;
  mid_item_t      mid_in, mid_out;
  logic [OCW-1:0] out_count;
  logic           res_push;
  out_item_t      res_data;
  logic           res_pop;

  zbts_front #(
    .MAX_TEXTURE_LOG2 (MAX_TEXTURE_LOG2),
    .MID_DEPTH        (MID_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_count (mid_count),
    .mid_push  (mid_push),
    .mid_data  (mid_in)
  );

  zbts_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_in),
    .pop       (mid_pop),
    .pop_data  (mid_out),
    .count     (mid_count)
  );

  zbts_back #(
    .MID_DEPTH (MID_DEPTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_count (mid_count),
    .mid_data  (mid_out),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (res_push),
    .out_data  (res_data)
  );

  assign out_empty = (out_count == '0);
  assign res_pop   = out_pop && !out_empty;

  zbts_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (res_pop),
    .pop_data  (out_data),
    .count     (out_count)
  );

endmodule
